// ===== rtl/core/base62_encode_64bit_unit_macros.svh =====
// ----------------------------------------------------------------------------
// base62 encoder assertion macros
// shared concurrent assertion forms, sampled on clock and held off in reset
// ----------------------------------------------------------------------------
`ifndef BASE62_ENCODE_64BIT_UNIT_MACROS_SVH
`define BASE62_ENCODE_64BIT_UNIT_MACROS_SVH

// same-cycle implication
`define B62E_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define B62E_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/b62e_pkg.sv =====
// ----------------------------------------------------------------------------
// base62 encoder package
// widths, divide-by-62 reciprocal constants, stage types and the digit glyph map
// ----------------------------------------------------------------------------
package b62e_pkg;

   localparam int unsigned VALUE_W        = 64;
   localparam int unsigned CHAR_W         = 7;
   localparam int unsigned NUM_DIGITS     = 11;
   localparam int unsigned REM_W          = 6;
   localparam int unsigned CHUNK_W        = 16;
   localparam int unsigned STEPS_PER_CELL = VALUE_W / CHUNK_W;

   // one chunk step divides {rem, chunk} by 62 as (x >> 1) / 31
   localparam int unsigned DIV_IN_W    = REM_W + CHUNK_W;
   localparam int unsigned HALF_W      = DIV_IN_W - 1;
   localparam int unsigned RECIP_W     = 22;
   localparam int unsigned PROD_W      = HALF_W + RECIP_W;
   localparam int unsigned RECIP_SHIFT = 26;
   localparam logic [RECIP_W-1:0] RECIP = 22'd2164803;

   // 62 = 64 - 2
   localparam int unsigned RADIX_SHIFT_HI = 6;
   localparam int unsigned RADIX_SHIFT_LO = 1;

   localparam logic [REM_W-1:0] RADIX     = 6'd62;
   localparam logic [REM_W-1:0] DEC_END   = 6'd10;
   localparam logic [REM_W-1:0] LOWER_END = 6'd36;

   localparam logic [CHAR_W-1:0] GLYPH_DIGIT_BASE = 7'd48;
   localparam logic [CHAR_W-1:0] GLYPH_LOWER_BASE = 7'd87;
   localparam logic [CHAR_W-1:0] GLYPH_UPPER_BASE = 7'd29;

   localparam int unsigned RSP_DATA_W = ((NUM_DIGITS * CHAR_W + 7) / 8) * 8;
   localparam int unsigned PAD_W      = RSP_DATA_W - NUM_DIGITS * CHAR_W;

   typedef logic [NUM_DIGITS-1:0][CHAR_W-1:0] char_array_type;

   typedef struct packed {
      logic [VALUE_W-1:0] word;
      logic [REM_W-1:0]   rem;
      char_array_type     chars;
   } stage_type;

   typedef struct packed {
      logic advance;
      logic valid;
   } lane_ctrl_type;

   function automatic logic [CHAR_W-1:0] glyph(input logic [REM_W-1:0] digit);
      logic [CHAR_W-1:0] code;
      code = GLYPH_DIGIT_BASE;
      priority if (digit < DEC_END) begin
         code = GLYPH_DIGIT_BASE + CHAR_W'(digit);
      end else if (digit < LOWER_END) begin
         code = GLYPH_LOWER_BASE + CHAR_W'(digit);
      end else if (digit < RADIX) begin
         code = GLYPH_UPPER_BASE + CHAR_W'(digit);
      end else begin
         code = GLYPH_DIGIT_BASE;
      end
      return code;
   endfunction

endpackage

// ===== rtl/core/base62_encode_64bit_unit.sv =====
// ----------------------------------------------------------------------------
// base62 encoder, 64-bit value to 11 ascii digits
// chain of eleven digit cells, each peeling off one base-62 digit, with a
// two-entry output buffer
//
//   channel  dir  tdata
//   req      in   [63:0] value
//   rsp      out  [6:0] char_0 (msd) .. [76:70] char_10 (lsd), [79:77] zero
//
// one beat per cycle sustained; 44 register steps (11 cells of 4 chunk steps)
// then the output register
// each chunk step holds one 21 by 22 bit reciprocal multiply
// the whole chain stalls only while both output entries are full
// reset clears the valid bits only
// ----------------------------------------------------------------------------
`include "base62_encode_64bit_unit_macros.svh"

module base62_encode_64bit_unit
   import b62e_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [VALUE_W-1:0]    req_tdata,   // value

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // char_0 .. char_10, zero pad
);

   logic          advance;
   logic          push;
   logic          pop;

   stage_type     cell_link  [NUM_DIGITS+1];
   logic          cell_valid [NUM_DIGITS+1];
   lane_ctrl_type cell_ctrl  [NUM_DIGITS];

   logic           out_valid_ff,  out_valid_in;
   char_array_type out_chars_ff,  out_chars_in;
   logic           skid_valid_ff, skid_valid_in;
   char_array_type skid_chars_ff, skid_chars_in;

   assign advance = !skid_valid_ff;

   always_comb begin
      cell_link[0].word  = req_tdata;
      cell_link[0].rem   = '0;
      cell_link[0].chars = '0;
      cell_valid[0]      = req_tvalid;
   end

   for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
      always_comb begin
         cell_ctrl[g].advance = advance;
         cell_ctrl[g].valid   = cell_valid[g];
      end

      b62e_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl[g]),
         .prev_stage (cell_link[g]),
         .next_valid (cell_valid[g+1]),
         .next_stage (cell_link[g+1])
      );
   end

   assign push = advance && cell_valid[NUM_DIGITS];
   assign pop  = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_chars_in  = out_chars_ff;
      skid_valid_in = skid_valid_ff;
      skid_chars_in = skid_chars_ff;
      priority if (pop) begin
         if (skid_valid_ff) begin
            out_chars_in  = skid_chars_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_chars_in = cell_link[NUM_DIGITS].chars;
         end
      end else if (!out_valid_ff) begin
         out_valid_in = push;
         out_chars_in = cell_link[NUM_DIGITS].chars;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_chars_in = cell_link[NUM_DIGITS].chars;
      end else begin
         skid_valid_in = skid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_chars_ff  <= out_chars_in;
      skid_chars_ff <= skid_chars_in;
   end

   assign req_tready = advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_chars_ff};

   `B62E_ASSERT(quotient_drained, cell_valid[NUM_DIGITS] && (cell_link[NUM_DIGITS].rem == '0), cell_link[NUM_DIGITS].word == '0, "value left after last digit")
   `B62E_ASSERT(skid_needs_out, skid_valid_ff, out_valid_ff, "skid entry without output entry")
   `B62E_ASSERT(out_drop_needs_take, !$past(reset) && $fell(out_valid_ff), $past(rsp_tready), "output beat dropped without take")
   `B62E_ASSERT_NEXT(skid_filled_on_stall, out_valid_ff && !rsp_tready && push, skid_valid_ff, "result lost while output stalled")

endmodule

// ===== rtl/core/b62e_step.sv =====
// ----------------------------------------------------------------------------
// base62 encoder chunk step
// divides the top 16-bit chunk plus running remainder by 62, rotates the quotient in
// ----------------------------------------------------------------------------
`include "base62_encode_64bit_unit_macros.svh"

module b62e_step
   import b62e_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lane_ctrl_type ctrl,
   input  stage_type     prev_stage,
   output logic          next_valid,
   output stage_type     next_stage
);

   logic [DIV_IN_W-1:0] dividend;
   logic [HALF_W-1:0]   half;
   logic [PROD_W-1:0]   product;
   logic [CHUNK_W-1:0]  quot;
   logic [DIV_IN_W-1:0] quot_x62;
   logic [DIV_IN_W-1:0] rem_wide;
   stage_type           stage_calc;

   logic                valid_ff, valid_in;
   stage_type           stage_ff, stage_in;

   always_comb begin
      dividend = {prev_stage.rem, prev_stage.word[VALUE_W-1 -: CHUNK_W]};
      half     = dividend[DIV_IN_W-1:1];
      product  = PROD_W'(half) * PROD_W'(RECIP);
      quot     = product[RECIP_SHIFT +: CHUNK_W];
      quot_x62 = (DIV_IN_W'(quot) << RADIX_SHIFT_HI) - (DIV_IN_W'(quot) << RADIX_SHIFT_LO);
      rem_wide = dividend - quot_x62;

      stage_calc.word  = {prev_stage.word[VALUE_W-CHUNK_W-1:0], quot};
      stage_calc.rem   = rem_wide[REM_W-1:0];
      stage_calc.chars = prev_stage.chars;
   end

   always_comb begin
      valid_in = ctrl.advance ? ctrl.valid : valid_ff;
      stage_in = ctrl.advance ? stage_calc : stage_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      stage_ff <= stage_in;
   end

   assign next_valid = valid_ff;
   assign next_stage = stage_ff;

   `B62E_ASSERT(rem_below_radix, valid_ff, stage_ff.rem < RADIX, "step remainder out of range")

endmodule

// ===== rtl/core/b62e_cell.sv =====
// ----------------------------------------------------------------------------
// base62 encoder digit cell
// four chunk steps divide the value by 62, the remainder becomes one ascii digit
// ----------------------------------------------------------------------------
module b62e_cell
   import b62e_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lane_ctrl_type ctrl,
   input  stage_type     prev_stage,
   output logic          next_valid,
   output stage_type     next_stage
);

   stage_type     link       [STEPS_PER_CELL+1];
   logic          link_valid [STEPS_PER_CELL+1];
   lane_ctrl_type step_ctrl  [STEPS_PER_CELL];

   always_comb begin
      link[0].word  = prev_stage.word;
      link[0].rem   = '0;
      link[0].chars = prev_stage.chars;
      link_valid[0] = ctrl.valid;
   end

   for (genvar g = 0; g < STEPS_PER_CELL; g++) begin : g_step
      always_comb begin
         step_ctrl[g].advance = ctrl.advance;
         step_ctrl[g].valid   = link_valid[g];
      end

      b62e_step u_step (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (step_ctrl[g]),
         .prev_stage (link[g]),
         .next_valid (link_valid[g+1]),
         .next_stage (link[g+1])
      );
   end

   // new digit enters at the low end, earlier digits move up
   always_comb begin
      next_valid       = link_valid[STEPS_PER_CELL];
      next_stage.word  = link[STEPS_PER_CELL].word;
      next_stage.rem   = link[STEPS_PER_CELL].rem;
      next_stage.chars = {link[STEPS_PER_CELL].chars[NUM_DIGITS-2:0],
                          glyph(link[STEPS_PER_CELL].rem)};
   end

endmodule
